// File: design/assert_macros.svh
// Assertion macros used by the rate controller's control module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QRC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/qrc_pkg.sv
// Types and constants of the quad rate controller and mixer.
package qrc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int KW         = 22;

	localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_CTRL     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_THRUST    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_ALPHA    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ALPHA  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEARN_COUNT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd6;

	// gyro, seed and setpoint scales as fractions of 2^32
	localparam logic signed [KW-1:0] K_GYRO = 22'sd1364099;
	localparam logic signed [KW-1:0] K_SEED = 22'sd1143819;
	localparam logic signed [KW-1:0] K_SETP = 22'sd749472;
	localparam logic [15:0]          SETP_ZERO = 16'd9999;

	typedef struct packed {
		logic [15:0] kp_gain;
		logic [9:0]  full_control_start;
		logic [9:0]  max_thrust;
		logic [15:0] rate_alpha;
		logic [15:0] offset_alpha;
		logic [15:0] offset_learn_count;
		logic [7:0]  send_interval;
	} qrc_cfg_t;

	typedef enum logic [2:0] {
		OP_SEED,
		OP_GYRO,
		OP_BIAS,
		OP_FILT,
		OP_SETP,
		OP_CORR
	} qrc_op_t;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       wb;
		qrc_op_t    op;
		logic [1:0] axis;
		logic       mix;
		logic       out_load;
	} qrc_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED_M,
		ST_SEED_W,
		ST_GYRO_M,
		ST_GYRO_W,
		ST_BIAS_M,
		ST_BIAS_W,
		ST_FILT_M,
		ST_FILT_W,
		ST_SETP_M,
		ST_SETP_W,
		ST_CORR_M,
		ST_CORR_W,
		ST_MIX,
		ST_CLAMP
	} qrc_state_t;

endpackage

// File: design/quad_rate_controller_mixer.sv
// Top level of the quadrotor P rate controller with X-frame motor mixer.
// Input channel: in_valid/in_ready carry one gyro sample, roll and pitch rate
// setpoints and thrust per item. Output channel: out_valid/out_ready carry four
// motor values, produced for every send_interval-th item starting with the first.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle; the user must
// write only while idle, since the block itself does not enforce it. One shared
// multiplier does every product, each in an issue and a write-back step:
// 3 per axis gyro/bias/filter steps, 2 setpoints, 3 gains, then mix and clamp.
// The bias steps run only while bias learning runs; an item that emits nothing
// skips mix and clamp. The very first item after reset adds seeding steps.
// in_ready is high only between items. A finished result waits in the output
// register; the next item is accepted meanwhile and, if it emits, holds in its
// last step until the waiting result is taken.
// Reset clears the counters, the seed flag and out_valid and restores register
// defaults; filter state is seeded from the first item after reset.
module quad_rate_controller_mixer #(
	parameter int GYRO_WIDTH  = 16,
	parameter int RATE_WIDTH  = 24,
	parameter int MOTOR_WIDTH = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [GYRO_WIDTH-1:0]   gyro_x,
	input  logic signed [GYRO_WIDTH-1:0]   gyro_y,
	input  logic signed [GYRO_WIDTH-1:0]   gyro_z,
	input  logic [15:0]                    roll_rate_setpoint,
	input  logic [15:0]                    pitch_rate_setpoint,
	input  logic [15:0]                    thrust_setpoint,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [MOTOR_WIDTH-1:0]         motor_front,
	output logic [MOTOR_WIDTH-1:0]         motor_right,
	output logic [MOTOR_WIDTH-1:0]         motor_back,
	output logic [MOTOR_WIDTH-1:0]         motor_left,
	input  logic                           cfg_we,
	input  logic [qrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import qrc_pkg::*;

	qrc_cfg_t cfg;
	qrc_cmd_t cmd;

	qrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	qrc_dp #(
		.GYRO_WIDTH  (GYRO_WIDTH),
		.RATE_WIDTH  (RATE_WIDTH),
		.MOTOR_WIDTH (MOTOR_WIDTH)
	) u_dp (
		.clk                 (clk),
		.cmd                 (cmd),
		.cfg                 (cfg),
		.gyro_x              (gyro_x),
		.gyro_y              (gyro_y),
		.gyro_z              (gyro_z),
		.roll_rate_setpoint  (roll_rate_setpoint),
		.pitch_rate_setpoint (pitch_rate_setpoint),
		.thrust_setpoint     (thrust_setpoint),
		.motor_front         (motor_front),
		.motor_right         (motor_right),
		.motor_back          (motor_back),
		.motor_left          (motor_left)
	);

endmodule

// File: design/qrc_cfg.sv
// Configuration register file of the quad rate controller.
module qrc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [qrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [qrc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output qrc_pkg::qrc_cfg_t                cfg
);
	import qrc_pkg::*;

	qrc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain            <= 16'd7680;
			cfg_q.full_control_start <= 10'd150;
			cfg_q.max_thrust         <= 10'd511;
			cfg_q.rate_alpha         <= 16'd5898;
			cfg_q.offset_alpha       <= 16'd66;
			cfg_q.offset_learn_count <= 16'd5000;
			cfg_q.send_interval      <= 8'd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_GAIN:       cfg_q.kp_gain            <= cfg_data;
				REG_FULL_CTRL:     cfg_q.full_control_start <= cfg_data[9:0];
				REG_MAX_THRUST:    cfg_q.max_thrust         <= cfg_data[9:0];
				REG_RATE_ALPHA:    cfg_q.rate_alpha         <= cfg_data;
				REG_OFFSET_ALPHA:  cfg_q.offset_alpha       <= cfg_data;
				REG_LEARN_COUNT:   cfg_q.offset_learn_count <= cfg_data;
				REG_SEND_INTERVAL: cfg_q.send_interval      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/qrc_dp.sv
// Datapath: shared multiplier, filter state, mixer and motor clamp.
module qrc_dp #(
	parameter int GYRO_WIDTH  = 16,
	parameter int RATE_WIDTH  = 24,
	parameter int MOTOR_WIDTH = 10
) (
	input  logic                          clk,
	input  qrc_pkg::qrc_cmd_t             cmd,
	input  qrc_pkg::qrc_cfg_t             cfg,
	input  logic signed [GYRO_WIDTH-1:0]  gyro_x,
	input  logic signed [GYRO_WIDTH-1:0]  gyro_y,
	input  logic signed [GYRO_WIDTH-1:0]  gyro_z,
	input  logic [15:0]                   roll_rate_setpoint,
	input  logic [15:0]                   pitch_rate_setpoint,
	input  logic [15:0]                   thrust_setpoint,
	output logic [MOTOR_WIDTH-1:0]        motor_front,
	output logic [MOTOR_WIDTH-1:0]        motor_right,
	output logic [MOTOR_WIDTH-1:0]        motor_back,
	output logic [MOTOR_WIDTH-1:0]        motor_left
);
	import qrc_pkg::*;

	localparam int RF = RATE_WIDTH - 6;
	localparam int SH = 32 - RF;
	localparam int AW = (GYRO_WIDTH > RATE_WIDTH + 1) ? GYRO_WIDTH : RATE_WIDTH + 1;
	localparam int PW = AW + KW;
	localparam int SW = PW + 2;
	localparam int CW = RATE_WIDTH + 10;
	localparam int MW = RATE_WIDTH + 24;
	localparam logic signed [SW-1:0] RHI = SW'((64'sd1 <<< (RATE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] RLO = SW'(-(64'sd1 <<< (RATE_WIDTH - 1)));
	localparam logic signed [MW-1:0] MTOP = MW'((64'sd1 <<< MOTOR_WIDTH) - 64'sd1);

	function automatic logic signed [RATE_WIDTH-1:0] sat_r(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		c = (v > RHI) ? RHI : ((v < RLO) ? RLO : v);
		return RATE_WIDTH'(c);
	endfunction

	// round to nearest, ties up
	function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v, input int s);
		logic signed [SW-1:0] h;
		h = SW'(1) <<< (s - 1);
		return (v + h) >>> s;
	endfunction

	function automatic logic [MOTOR_WIDTH-1:0] to_motor(input logic signed [MW-1:0] m);
		logic signed [MW-1:0] u;
		u = m >>> RF;
		if (m < 0)
			return '0;
		else if (u > MTOP)
			return MTOP[MOTOR_WIDTH-1:0];
		else
			return u[MOTOR_WIDTH-1:0];
	endfunction

	logic signed [GYRO_WIDTH-1:0] g_q [3];
	logic [15:0]                  spin_q [2];
	logic [15:0]                  thrust_q;
	logic signed [RATE_WIDTH-1:0] x_q;
	logic signed [RATE_WIDTH-1:0] b_q [3];
	logic signed [RATE_WIDTH-1:0] f_q [3];
	logic signed [RATE_WIDTH-1:0] sp_q [2];
	logic signed [CW-1:0]         corr_q [3];
	logic signed [PW-1:0]         p_q;
	logic signed [MW-1:0]         msum_q [4];
	logic signed [MW-1:0]         lhi_q;
	logic signed [MW-1:0]         llo_q;
	logic [MOTOR_WIDTH-1:0]       mot_q [4];

	logic signed [RATE_WIDTH:0]   dxb, dfil, dcor;
	logic signed [RATE_WIDTH-1:0] satxb, spv;
	logic signed [16:0]           sdiff;
	logic signed [AW-1:0]         opa;
	logic signed [KW-1:0]         opb;
	logic signed [SW-1:0]         pe;

	always_comb begin
		dxb   = (RATE_WIDTH + 1)'(x_q) - (RATE_WIDTH + 1)'(b_q[cmd.axis]);
		satxb = sat_r(SW'(dxb));
		dfil  = (RATE_WIDTH + 1)'(satxb) - (RATE_WIDTH + 1)'(f_q[cmd.axis]);
		spv   = (cmd.axis == 2'd2) ? '0 : sp_q[cmd.axis[0]];
		dcor  = (RATE_WIDTH + 1)'(f_q[cmd.axis]) - (RATE_WIDTH + 1)'(spv);
		sdiff = $signed({1'b0, SETP_ZERO}) - $signed({1'b0, spin_q[cmd.axis[0]]});
		unique case (cmd.op)
			OP_SEED: begin
				opa = AW'(g_q[cmd.axis]);
				opb = K_SEED;
			end
			OP_GYRO: begin
				opa = AW'(g_q[cmd.axis]);
				opb = K_GYRO;
			end
			OP_BIAS: begin
				opa = AW'(dxb);
				opb = $signed({6'd0, cfg.offset_alpha});
			end
			OP_FILT: begin
				opa = AW'(dfil);
				opb = $signed({6'd0, cfg.rate_alpha});
			end
			OP_SETP: begin
				opa = AW'(sdiff);
				opb = K_SETP;
			end
			OP_CORR: begin
				opa = AW'(dcor);
				opb = $signed({6'd0, cfg.kp_gain});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
		pe = SW'(p_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			g_q[0]    <= gyro_x;
			g_q[1]    <= gyro_y;
			g_q[2]    <= gyro_z;
			spin_q[0] <= roll_rate_setpoint;
			spin_q[1] <= pitch_rate_setpoint;
			thrust_q  <= thrust_setpoint;
		end
		if (cmd.mul)
			p_q <= opa * opb;
		if (cmd.wb) begin
			unique case (cmd.op)
				OP_SEED: begin
					b_q[cmd.axis] <= sat_r(rnd(pe, SH));
					f_q[cmd.axis] <= sat_r(rnd(pe, SH));
				end
				OP_GYRO: x_q <= sat_r(rnd(pe, SH));
				OP_BIAS: b_q[cmd.axis] <= sat_r(SW'(b_q[cmd.axis]) + rnd(pe, 16));
				OP_FILT: f_q[cmd.axis] <= sat_r(SW'(f_q[cmd.axis]) + rnd(pe, 16));
				OP_SETP: sp_q[cmd.axis[0]] <= sat_r(rnd(pe, SH));
				OP_CORR: corr_q[cmd.axis] <= CW'(rnd(pe, 8));
				default: ;
			endcase
		end
	end

	// thrust band and X-frame mix
	logic signed [13:0]   cap4;
	logic signed [19:0]   t4, tq;
	logic [11:0]          band, bfull;
	logic signed [MW-1:0] thr, bsh, c0, c1, c2;

	always_comb begin
		cap4  = $signed({2'b0, cfg.max_thrust, 2'b0})
			- $signed(14'(3 * {4'd0, cfg.full_control_start}));
		t4    = $signed({2'b0, thrust_q, 2'b0});
		bfull = 12'((3 * {2'd0, cfg.full_control_start}) >> 2);
		tq    = t4;
		if (t4 >= 20'(cap4)) begin
			tq   = 20'(cap4);
			band = bfull;
		end else if (thrust_q == 16'd0)
			band = '0;
		else if (thrust_q < {6'd0, cfg.full_control_start})
			band = 12'((3 * {2'd0, thrust_q[9:0]}) >> 2);
		else
			band = bfull;
		thr = MW'(tq) <<< (RF - 2);
		bsh = MW'($signed({1'b0, band})) <<< RF;
		c0  = MW'(corr_q[0]);
		c1  = MW'(corr_q[1]);
		c2  = MW'(corr_q[2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			msum_q[0] <= thr + c0 + c1 + c2;
			msum_q[1] <= thr - c0 + c1 - c2;
			msum_q[2] <= thr - c0 - c1 + c2;
			msum_q[3] <= thr + c0 - c1 - c2;
			lhi_q     <= thr + bsh;
			llo_q     <= thr - bsh;
		end
		if (cmd.out_load) begin
			for (int i = 0; i < 4; i++) begin
				if (msum_q[i] < llo_q)
					mot_q[i] <= to_motor(llo_q);
				else if (msum_q[i] > lhi_q)
					mot_q[i] <= to_motor(lhi_q);
				else
					mot_q[i] <= to_motor(msum_q[i]);
			end
		end
	end

	assign motor_front = mot_q[0];
	assign motor_right = mot_q[1];
	assign motor_back  = mot_q[2];
	assign motor_left  = mot_q[3];

endmodule

// File: design/qrc_ctrl.sv
// Controller: step sequencer, learn and send counters, output valid.
`include "assert_macros.svh"
module qrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  qrc_pkg::qrc_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output qrc_pkg::qrc_cmd_t cmd
);
	import qrc_pkg::*;

	qrc_state_t state_q, state_d;
	logic [1:0]  axis_q, axis_d;
	logic        seeded_q, learning_q, emit_q, out_valid_q;
	logic [15:0] learn_q, learn_n;
	logic [7:0]  send_q, interval;
	logic [8:0]  send_inc;
	logic        in_acc;

	assign in_acc   = in_valid && in_ready;
	assign interval = (cfg.send_interval == 8'd0) ? 8'd1 : cfg.send_interval;
	assign learn_n  = (learn_q == 16'hFFFF) ? learn_q : learn_q + 16'd1;
	assign send_inc = {1'b0, send_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			seeded_q    <= 1'b0;
			learning_q  <= 1'b0;
			emit_q      <= 1'b0;
			learn_q     <= '0;
			send_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			if (in_acc) begin
				seeded_q   <= 1'b1;
				learn_q    <= learn_n;
				learning_q <= learn_n < cfg.offset_learn_count;
				emit_q     <= send_q == 8'd0;
				send_q     <= (send_inc >= {1'b0, interval}) ? 8'd0 : send_inc[7:0];
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					axis_d   = '0;
					state_d  = seeded_q ? ST_GYRO_M : ST_SEED_M;
				end
			end
			ST_SEED_M: begin
				cmd.op  = OP_SEED;
				cmd.mul = 1'b1;
				state_d = ST_SEED_W;
			end
			ST_SEED_W: begin
				cmd.op  = OP_SEED;
				cmd.wb  = 1'b1;
				axis_d  = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				state_d = (axis_q == 2'd2) ? ST_GYRO_M : ST_SEED_M;
			end
			ST_GYRO_M: begin
				cmd.op  = OP_GYRO;
				cmd.mul = 1'b1;
				state_d = ST_GYRO_W;
			end
			ST_GYRO_W: begin
				cmd.op  = OP_GYRO;
				cmd.wb  = 1'b1;
				state_d = learning_q ? ST_BIAS_M : ST_FILT_M;
			end
			ST_BIAS_M: begin
				cmd.op  = OP_BIAS;
				cmd.mul = 1'b1;
				state_d = ST_BIAS_W;
			end
			ST_BIAS_W: begin
				cmd.op  = OP_BIAS;
				cmd.wb  = 1'b1;
				state_d = ST_FILT_M;
			end
			ST_FILT_M: begin
				cmd.op  = OP_FILT;
				cmd.mul = 1'b1;
				state_d = ST_FILT_W;
			end
			ST_FILT_W: begin
				cmd.op  = OP_FILT;
				cmd.wb  = 1'b1;
				axis_d  = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				state_d = (axis_q == 2'd2) ? ST_SETP_M : ST_GYRO_M;
			end
			ST_SETP_M: begin
				cmd.op  = OP_SETP;
				cmd.mul = 1'b1;
				state_d = ST_SETP_W;
			end
			ST_SETP_W: begin
				cmd.op  = OP_SETP;
				cmd.wb  = 1'b1;
				axis_d  = (axis_q == 2'd1) ? 2'd0 : axis_q + 2'd1;
				state_d = (axis_q == 2'd1) ? ST_CORR_M : ST_SETP_M;
			end
			ST_CORR_M: begin
				cmd.op  = OP_CORR;
				cmd.mul = 1'b1;
				state_d = ST_CORR_W;
			end
			ST_CORR_W: begin
				cmd.op  = OP_CORR;
				cmd.wb  = 1'b1;
				axis_d  = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				if (axis_q != 2'd2)
					state_d = ST_CORR_M;
				else
					state_d = emit_q ? ST_MIX : ST_IDLE;
			end
			ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

	`QRC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || out_ready, "result overwritten")
	`QRC_ASSERT_NEXT(a_seed_sticky, seeded_q, seeded_q, "seeded flag dropped")
	`QRC_ASSERT_NEXT(a_send_range, in_acc, send_q < $past(interval), "send counter out of range")
	`QRC_ASSERT_NEXT(a_start, in_acc, state_q == ST_SEED_M || state_q == ST_GYRO_M, "bad start")

endmodule
